@@ design/qrm_pkg.sv @@
`timescale 1ns / 1ps
package qrm_pkg;

    localparam int QuatWidth  = 16;
    localparam int ProdWidth  = 32;
    localparam int NormWidth  = 33;
    localparam int NumWidth   = 35;
    localparam int RemWidth   = 34;
    localparam int QuoWidth   = 16;
    localparam int OutWidth   = 16;
    localparam int NumEntries = 9;
    localparam int DivSteps   = QuoWidth;

    typedef struct packed {
        logic                  neg;
        logic [RemWidth-1:0]   rem;
        logic [QuoWidth-1:0]   quo;
    } lane_t;

    typedef struct packed {
        lane_t [NumEntries-1:0] lane;
        logic [NormWidth-1:0]   norm;
        logic                   zero;
    } div_t;

endpackage

@@ design/qrm_products.sv @@
`timescale 1ns / 1ps
module qrm_products (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [qrm_pkg::QuatWidth-1:0] quat_x,
    input  logic signed [qrm_pkg::QuatWidth-1:0] quat_y,
    input  logic signed [qrm_pkg::QuatWidth-1:0] quat_z,
    input  logic signed [qrm_pkg::QuatWidth-1:0] quat_w,
    output logic                                out_valid,
    input  logic                                out_ready,
    output qrm_pkg::div_t                       out_data
);
    import qrm_pkg::*;

    logic signed [ProdWidth-1:0] xx_reg, yy_reg, zz_reg, ww_reg;
    logic signed [ProdWidth-1:0] xy_reg, xz_reg, yz_reg, xw_reg, yw_reg, zw_reg;
    logic v1_reg, v2_reg;
    logic rdy1, rdy2;
    div_t s2_reg, s2_next;

    logic signed [NumWidth-1:0] e_xx, e_yy, e_zz, e_ww, e_xy, e_xz, e_yz, e_xw, e_yw, e_zw;
    logic signed [NumWidth-1:0] num [NumEntries];
    logic [NumWidth-1:0]        mag [NumEntries];
    logic [NormWidth-1:0]       norm;

    assign rdy2     = ~v2_reg | out_ready;
    assign rdy1     = ~v1_reg | rdy2;
    assign in_ready = rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= in_valid;
            if (rdy2)
                v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            xx_reg <= quat_x * quat_x;
            yy_reg <= quat_y * quat_y;
            zz_reg <= quat_z * quat_z;
            ww_reg <= quat_w * quat_w;
            xy_reg <= quat_x * quat_y;
            xz_reg <= quat_x * quat_z;
            yz_reg <= quat_y * quat_z;
            xw_reg <= quat_x * quat_w;
            yw_reg <= quat_y * quat_w;
            zw_reg <= quat_z * quat_w;
        end
        if (rdy2 && v1_reg)
            s2_reg <= s2_next;
    end

    assign e_xx = NumWidth'(xx_reg);
    assign e_yy = NumWidth'(yy_reg);
    assign e_zz = NumWidth'(zz_reg);
    assign e_ww = NumWidth'(ww_reg);
    assign e_xy = NumWidth'(xy_reg);
    assign e_xz = NumWidth'(xz_reg);
    assign e_yz = NumWidth'(yz_reg);
    assign e_xw = NumWidth'(xw_reg);
    assign e_yw = NumWidth'(yw_reg);
    assign e_zw = NumWidth'(zw_reg);

    // squares are never negative, so zero extension is exact
    assign norm = {1'b0, xx_reg} + {1'b0, yy_reg} + {1'b0, zz_reg} + {1'b0, ww_reg};

    always_comb
    begin
        num[0] = e_xx - e_yy - e_zz + e_ww;
        num[1] = (e_xy - e_zw) <<< 1;
        num[2] = (e_xz + e_yw) <<< 1;
        num[3] = (e_xy + e_zw) <<< 1;
        num[4] = e_yy - e_xx - e_zz + e_ww;
        num[5] = (e_yz - e_xw) <<< 1;
        num[6] = (e_xz - e_yw) <<< 1;
        num[7] = (e_yz + e_xw) <<< 1;
        num[8] = e_zz - e_xx - e_yy + e_ww;
        s2_next.norm = norm;
        s2_next.zero = (norm == '0);
        for (int i = 0; i < NumEntries; i++)
        begin
            mag[i] = num[i][NumWidth-1] ? NumWidth'(-num[i]) : NumWidth'(num[i]);
            s2_next.lane[i].neg = num[i][NumWidth-1];
            // |num| <= norm, so the start remainder is below twice the divisor
            s2_next.lane[i].rem = mag[i][RemWidth-1:0];
            s2_next.lane[i].quo = '0;
        end
    end

    assign out_valid = v2_reg;
    assign out_data  = s2_reg;

endmodule

@@ design/qrm_div_stage.sv @@
`timescale 1ns / 1ps
module qrm_div_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  qrm_pkg::div_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output qrm_pkg::div_t out_data
);
    import qrm_pkg::*;

    logic  valid_reg;
    div_t  data_reg, data_next;
    logic  [RemWidth-1:0] diff [NumEntries];
    logic  [RemWidth-1:0] keep [NumEntries];
    logic  take [NumEntries];

    assign in_ready = ~valid_reg | out_ready;

    // one restoring step per lane: compare, subtract, shift for next bit
    always_comb
    begin
        data_next = in_data;
        for (int i = 0; i < NumEntries; i++)
        begin
            take[i] = (in_data.lane[i].rem >= RemWidth'(in_data.norm));
            diff[i] = in_data.lane[i].rem - RemWidth'(in_data.norm);
            keep[i] = take[i] ? diff[i] : in_data.lane[i].rem;
            data_next.lane[i].rem = {keep[i][RemWidth-2:0], 1'b0};
            data_next.lane[i].quo = {in_data.lane[i].quo[QuoWidth-2:0], take[i]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

@@ design/qrm_round.sv @@
`timescale 1ns / 1ps
module qrm_round (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  qrm_pkg::div_t                         in_data,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [qrm_pkg::OutWidth-1:0]   entry [qrm_pkg::NumEntries],
    output logic                                  zero_norm
);
    import qrm_pkg::*;

    logic valid_reg;
    logic signed [OutWidth-1:0] entry_reg [NumEntries];
    logic signed [OutWidth-1:0] entry_next [NumEntries];
    logic zero_reg;
    logic [QuoWidth:0] rnd [NumEntries];
    logic [OutWidth-1:0] mag [NumEntries];

    assign in_ready = ~valid_reg | out_ready;

    // quotient carries one extra fraction bit: add one half, drop it
    always_comb
    begin
        for (int i = 0; i < NumEntries; i++)
        begin
            rnd[i] = {1'b0, in_data.lane[i].quo} + (QuoWidth+1)'(1);
            mag[i] = rnd[i][QuoWidth:1];
            if (in_data.zero)
                entry_next[i] = '0;
            else if (in_data.lane[i].neg)
                entry_next[i] = -signed'(mag[i]);
            else
                entry_next[i] = signed'(mag[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            entry_reg <= entry_next;
            zero_reg  <= in_data.zero;
        end
    end

    assign out_valid = valid_reg;
    assign entry     = entry_reg;
    assign zero_norm = zero_reg;

endmodule

@@ design/quaternion_to_rotation_matrix_top.sv @@
`timescale 1ns / 1ps
// Pipeline: 2 product/sum stages, 16 restoring divide stages and 1 rounding stage
// lie between input transfer and result valid.
// Throughput: one item per cycle while out_ready is high; every stage has its own
// valid bit and bubbles close up when the output is stalled.
// Reset: rst_n clears all stage valid bits; no datapath state is kept.
module quaternion_to_rotation_matrix_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [qrm_pkg::QuatWidth-1:0] quat_x,
    input  logic signed [qrm_pkg::QuatWidth-1:0] quat_y,
    input  logic signed [qrm_pkg::QuatWidth-1:0] quat_z,
    input  logic signed [qrm_pkg::QuatWidth-1:0] quat_w,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [qrm_pkg::OutWidth-1:0]  m00,
    output logic signed [qrm_pkg::OutWidth-1:0]  m01,
    output logic signed [qrm_pkg::OutWidth-1:0]  m02,
    output logic signed [qrm_pkg::OutWidth-1:0]  m10,
    output logic signed [qrm_pkg::OutWidth-1:0]  m11,
    output logic signed [qrm_pkg::OutWidth-1:0]  m12,
    output logic signed [qrm_pkg::OutWidth-1:0]  m20,
    output logic signed [qrm_pkg::OutWidth-1:0]  m21,
    output logic signed [qrm_pkg::OutWidth-1:0]  m22,
    output logic                                 zero_norm
);
    import qrm_pkg::*;

    div_t stg_data  [DivSteps+1];
    logic stg_valid [DivSteps+1];
    logic stg_ready [DivSteps+1];
    logic signed [OutWidth-1:0] entry [NumEntries];

    qrm_products u_products (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .quat_x    (quat_x),
        .quat_y    (quat_y),
        .quat_z    (quat_z),
        .quat_w    (quat_w),
        .out_valid (stg_valid[0]),
        .out_ready (stg_ready[0]),
        .out_data  (stg_data[0])
    );

    for (genvar s = 0; s < DivSteps; s++)
    begin : g_div
        qrm_div_stage u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stg_valid[s]),
            .in_ready  (stg_ready[s]),
            .in_data   (stg_data[s]),
            .out_valid (stg_valid[s+1]),
            .out_ready (stg_ready[s+1]),
            .out_data  (stg_data[s+1])
        );
    end

    qrm_round u_round (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (stg_valid[DivSteps]),
        .in_ready  (stg_ready[DivSteps]),
        .in_data   (stg_data[DivSteps]),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .entry     (entry),
        .zero_norm (zero_norm)
    );

    assign m00 = entry[0];
    assign m01 = entry[1];
    assign m02 = entry[2];
    assign m10 = entry[3];
    assign m11 = entry[4];
    assign m12 = entry[5];
    assign m20 = entry[6];
    assign m21 = entry[7];
    assign m22 = entry[8];

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;

    typedef struct {
        logic signed [15:0] ent [9];
        logic               zn;
    } rot_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [15:0] quat_x = '0, quat_y = '0, quat_z = '0, quat_w = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
    logic zero_norm;

    int err_cnt = 0;
    int send_idle = 0;
    int recv_stall = 0;

    quaternion_to_rotation_matrix_top uut (.*);

    always #4 clk = ~clk;

    task automatic report(input string msg);
        $display("mismatch: %s", msg);
        err_cnt++;
    endtask

    // round(num * 2^14 / den), ties away from zero, then clamp to 16 bits
    function automatic logic signed [15:0] scale_q214(input longint num, input longint den);
        longint mag, q;
        mag = (num < 0) ? -num : num;
        q = ((mag <<< 15) + den) / (den <<< 1);
        if (num < 0)
            q = -q;
        if (q > 32767)
            q = 32767;
        if (q < -32768)
            q = -32768;
        return q[15:0];
    endfunction

    function automatic rot_t rotation_of(input logic signed [15:0] qx, qy, qz, qw);
        rot_t r;
        longint x, y, z, w, n;
        longint num [9];
        x = qx;
        y = qy;
        z = qz;
        w = qw;
        n = x*x + y*y + z*z + w*w;
        r.zn = (n == 0);
        num[0] = x*x - y*y - z*z + w*w;
        num[1] = 2 * (x*y - z*w);
        num[2] = 2 * (x*z + y*w);
        num[3] = 2 * (x*y + z*w);
        num[4] = -x*x + y*y - z*z + w*w;
        num[5] = 2 * (y*z - x*w);
        num[6] = 2 * (x*z - y*w);
        num[7] = 2 * (y*z + x*w);
        num[8] = -x*x - y*y + z*z + w*w;
        for (int i = 0; i < 9; i++)
            r.ent[i] = r.zn ? 16'sd0 : scale_q214(num[i], n);
        return r;
    endfunction

    class matrix_board;
        rot_t pending [$];

        function void note_quat(logic signed [15:0] qx, qy, qz, qw);
            pending.push_back(rotation_of(qx, qy, qz, qw));
        endfunction

        task check_matrix(rot_t got);
            rot_t want;
            if (pending.size() == 0)
            begin
                report("matrix with no quaternion outstanding");
                return;
            end
            want = pending.pop_front();
            for (int i = 0; i < 9; i++)
                if (got.ent[i] !== want.ent[i])
                    report($sformatf("m%0d%0d got %0d want %0d", i / 3, i % 3,
                        got.ent[i], want.ent[i]));
            if (got.zn !== want.zn)
                report($sformatf("zero_norm got %b want %b", got.zn, want.zn));
        endtask
    endclass

    matrix_board board = new();

    // note accepted quaternions and check results at rising edge, choose ready at falling edge
    always @(posedge clk)
    begin
        rot_t got;
        if (rst_n && in_valid && in_ready)
            board.note_quat(quat_x, quat_y, quat_z, quat_w);
        if (rst_n && out_valid && out_ready)
        begin
            got.ent = '{m00, m01, m02, m10, m11, m12, m20, m21, m22};
            got.zn = zero_norm;
            board.check_matrix(got);
        end
    end

    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall);

    // valid is dropped by the next idle cycle or by drain
    task automatic send_quat(input logic signed [15:0] qx, qy, qz, qw);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        quat_x <= qx;
        quat_y <= qy;
        quat_z <= qz;
        quat_w <= qw;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [15:0] rand_comp(input int kind);
        case (kind)
            0: return 16'($urandom);
            1: return 16'($urandom_range(255)) - 16'd128;
            2: return {$urandom_range(1) ? 4'hf : 4'h0, 12'($urandom)};
            default: return 16'($urandom_range(6)) - 16'd3;
        endcase
    endfunction

    task automatic random_phase(input int count);
        int k;
        for (int i = 0; i < count; i++)
        begin
            k = $urandom_range(9);
            if (k == 0)
                send_quat(0, 0, 0, 0);
            else
                send_quat(rand_comp(k % 4), rand_comp($urandom_range(3)),
                          rand_comp($urandom_range(3)), rand_comp(k % 3));
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        // directed corners: zero, axes, extremes, ties, mixed signs
        send_quat(0, 0, 0, 0);
        send_quat(0, 0, 0, 16'sd4096);
        send_quat(16'sd4096, 0, 0, 0);
        send_quat(0, 16'sd4096, 0, 0);
        send_quat(0, 0, 16'sd4096, 0);
        send_quat(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
        send_quat(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
        send_quat(-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767);
        send_quat(16'sd1, 0, 0, 0);
        send_quat(0, 0, 0, -16'sd1);
        send_quat(16'sd1, 16'sd1, 16'sd1, 16'sd1);
        send_quat(16'sd1, 16'sd2, 16'sd3, 16'sd4);
        send_quat(-16'sd3, 16'sd1, 0, 16'sd1);
        send_quat(16'sd2896, 0, 0, 16'sd2896);
        send_quat(16'sd32767, -16'sd32768, 16'sd1, -16'sd1);
        send_quat(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
        send_quat(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
        drain();
        send_idle = 0;  recv_stall = 0;  random_phase(480);
        send_idle = 53; recv_stall = 0;  random_phase(480);
        drain();
        send_idle = 0;  recv_stall = 53; random_phase(480);
        send_idle = 37; recv_stall = 37; random_phase(480);
        drain();
        recv_stall = 0;
        repeat (40) @(negedge clk);
        if (err_cnt == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("tb_top: errors");
        $finish;
    end

endmodule
